// ===== rtl/iwcm_pkg.sv =====
`default_nettype none

package iwcm_pkg;

  localparam int unsigned MAX_DIM    = 512;
  localparam int unsigned DIM_W      = $clog2(MAX_DIM);
  localparam int unsigned ADDR_W     = 2 * DIM_W;
  localparam int unsigned SIZE_W     = DIM_W + 1;
  localparam int unsigned CRD_W      = SIZE_W + 1;
  localparam int unsigned MAX_SQUARE = 31;
  localparam int unsigned SQ_W       = 5;
  localparam int unsigned RAD_W      = SQ_W;
  localparam int unsigned PT_W       = 16;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned PIX_W      = 3 * CH_W;
  localparam int unsigned FRAC_W     = 8;
  localparam int unsigned MEAN_W     = 16;
  localparam int unsigned MEAN_MAX   = 255 << FRAC_W;
  localparam int unsigned SUM_W      = $clog2(MAX_SQUARE * MAX_SQUARE * 255 + 1);
  localparam int unsigned DVD_W      = SUM_W + FRAC_W;
  localparam int unsigned DIV_STEPS  = (DVD_W + 1) / 2;
  localparam int unsigned DIV_BITS   = 2 * DIV_STEPS;
  localparam int unsigned DSR_W      = $clog2(MAX_SQUARE * MAX_SQUARE + 1);
  localparam int unsigned DCNT_W     = $clog2(DIV_STEPS + 1);
  localparam int unsigned CFG_W      = SIZE_W;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SQUARE = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLACE,
    ST_CLAMP,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } iwcm_state_e;

  typedef struct packed {
    logic scan;
    logic acc_clr;
    logic div_start;
    logic out_load;
  } iwcm_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/image_window_color_mean.sv =====
// Window colour mean over a stored RGB image.
//
// Input channel (in_valid_i/in_ready_o): mode 0 is a pixel write, stored in
// the pixel RAM at the transfer; mode 1 is a query at a normalised X,Y point.
// A query missing a coordinate, or arriving before any pixel write, is dropped.
// A query scans square_size^2 pixels from the pixel RAM, one read per cycle,
// then runs a radix-4 divider for the 8.8 means; a square of 0 skips both
// and gives zero means. in_ready_o stays low from the query transfer until
// the result is loaded into the output register, so queries do not overlap;
// writes and dropped queries go back to back.
// Output channel (out_valid_o/out_ready_i): the result sits in an output
// register; the next item is taken while it waits. If the receiver stalls
// and a new result is ready, the sequencer holds until the register frees.
// Configuration writes (cfg_we_i) take effect at once; the user must make them
// only while the block is idle, as the block itself does not enforce it.
// Reset clears the loaded flag, the sequencer and the output valid, and
// sets square 5, image 512 x 512. The pixel RAM is not cleared: only
// written pixels may be read.
`default_nettype none

module image_window_color_mean (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [iwcm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [iwcm_pkg::CFG_W-1:0]      cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            mode_i,
  input  wire logic [8:0]                      pixel_col_i,
  input  wire logic [8:0]                      pixel_row_i,
  input  wire logic [iwcm_pkg::CH_W-1:0]       red_in_i,
  input  wire logic [iwcm_pkg::CH_W-1:0]       green_in_i,
  input  wire logic [iwcm_pkg::CH_W-1:0]       blue_in_i,
  input  wire logic [iwcm_pkg::PT_W-1:0]       point_x_i,
  input  wire logic [iwcm_pkg::PT_W-1:0]       point_y_i,
  input  wire logic                            has_x_i,
  input  wire logic                            has_y_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [iwcm_pkg::MEAN_W-1:0]     mean_red_o,
  output logic      [iwcm_pkg::MEAN_W-1:0]     mean_green_o,
  output logic      [iwcm_pkg::MEAN_W-1:0]     mean_blue_o
);

  import iwcm_pkg::*;

  function automatic logic signed [CRD_W-1:0] place_org(
    input logic [SIZE_W-1:0] ps,
    input logic [SIZE_W-1:0] size,
    input logic [RAD_W-1:0]  rad
  );
    logic signed [CRD_W-1:0] p;
    logic signed [CRD_W-1:0] r;
    logic signed [CRD_W-1:0] hi;
    p  = $signed({1'b0, ps});
    r  = $signed({{(CRD_W-RAD_W){1'b0}}, rad});
    hi = $signed({1'b0, size}) - r;
    if (p < r) p = r;
    if (p > hi) p = hi;
    return p - r;
  endfunction

  iwcm_state_e state_q, state_d;
  iwcm_ctl_t   ctl;

  logic [SQ_W-1:0]   sq_cfg_q;
  logic [SIZE_W-1:0] w_cfg_q, h_cfg_q;
  logic              loaded_q;

  logic [SQ_W-1:0]   sq_eff, sq_last;
  logic [SIZE_W-1:0] w_eff, h_eff;
  logic [RAD_W-1:0]  rad;

  logic              in_xfer, query_go, scan_last;
  logic [PT_W-1:0]   px_q, py_q;
  logic [SIZE_W-1:0] pxs_q, pys_q;
  logic [PT_W+SIZE_W-1:0] prod_x, prod_y;
  logic signed [CRD_W-1:0] x0_q, y0_q, xs, ys;
  logic [SQ_W-1:0]   i_q, j_q;
  logic              zero_q;
  logic              in_img;
  logic              rd_vld_q, rd_in_q;
  logic [PIX_W-1:0]  rd_data;
  logic [SUM_W-1:0]  sum_r_q, sum_g_q, sum_b_q;
  logic [DSR_W-1:0]  samples;
  logic              busy_r, busy_g, busy_b;
  logic [MEAN_W-1:0] quot_r, quot_g, quot_b;
  logic              out_valid_q;
  logic [MEAN_W-1:0] mean_r_q, mean_g_q, mean_b_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_cfg_q <= SQ_W'(5);
      w_cfg_q  <= SIZE_W'(MAX_DIM);
      h_cfg_q  <= SIZE_W'(MAX_DIM);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_SQUARE) begin
        sq_cfg_q <= cfg_data_i[SQ_W-1:0];
      end else if (cfg_idx_i == REG_WIDTH) begin
        w_cfg_q <= cfg_data_i;
      end else if (cfg_idx_i == REG_HEIGHT) begin
        h_cfg_q <= cfg_data_i;
      end
    end
  end

  assign sq_eff  = (sq_cfg_q > SQ_W'(MAX_SQUARE)) ? SQ_W'(MAX_SQUARE) : sq_cfg_q;
  assign w_eff   = (w_cfg_q > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : w_cfg_q;
  assign h_eff   = (h_cfg_q > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : h_cfg_q;
  assign rad     = RAD_W'(({1'b0, sq_eff} + (SQ_W+1)'(1)) >> 1);
  assign sq_last = sq_eff - 1'b1;
  assign samples = {{(DSR_W-SQ_W){1'b0}}, sq_eff} * {{(DSR_W-SQ_W){1'b0}}, sq_eff};

  assign in_xfer   = in_valid_i && in_ready_o;
  assign query_go  = in_xfer && mode_i && loaded_q && has_x_i && has_y_i;
  assign scan_last = (i_q == sq_last) && (j_q == sq_last);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (query_go) state_d = ST_PLACE;
      ST_PLACE:    state_d = ST_CLAMP;
      ST_CLAMP:    state_d = (sq_eff == '0) ? ST_DONE : ST_SCAN;
      ST_SCAN:     if (scan_last) state_d = ST_DRAIN;
      ST_DRAIN:    state_d = ST_DIV_GO;
      ST_DIV_GO:   state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: if (!busy_r) state_d = ST_DONE;
      ST_DONE:     if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl           = '0;
    ctl.scan      = (state_q == ST_SCAN);
    ctl.acc_clr   = (state_q == ST_CLAMP);
    ctl.div_start = (state_q == ST_DIV_GO);
    ctl.out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
    in_ready_o    = (state_q == ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      loaded_q <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= ctl.scan;
      if (in_xfer && !mode_i) begin
        loaded_q <= 1'b1;
      end
    end
  end

  // query placement
  assign prod_x = px_q * w_eff;
  assign prod_y = py_q * h_eff;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      px_q <= point_x_i;
      py_q <= point_y_i;
    end
    if (state_q == ST_PLACE) begin
      pxs_q <= prod_x[PT_W+SIZE_W-1 -: SIZE_W];
      pys_q <= prod_y[PT_W+SIZE_W-1 -: SIZE_W];
    end
    if (ctl.acc_clr) begin
      x0_q   <= place_org(pxs_q, w_eff, rad);
      y0_q   <= place_org(pys_q, h_eff, rad);
      zero_q <= (sq_eff == '0);
      i_q    <= '0;
      j_q    <= '0;
    end else if (ctl.scan) begin
      if (j_q == sq_last) begin
        j_q <= '0;
        i_q <= i_q + 1'b1;
      end else begin
        j_q <= j_q + 1'b1;
      end
    end
  end

  // scan over the window
  assign xs = x0_q + $signed({{(CRD_W-SQ_W){1'b0}}, i_q});
  assign ys = y0_q + $signed({{(CRD_W-SQ_W){1'b0}}, j_q});
  assign in_img = !xs[CRD_W-1] && (xs[SIZE_W-1:0] < w_eff) &&
                  !ys[CRD_W-1] && (ys[SIZE_W-1:0] < h_eff);

  iwcm_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (PIX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (in_xfer && !mode_i),
    .waddr_i ({pixel_row_i, pixel_col_i}),
    .wdata_i ({red_in_i, green_in_i, blue_in_i}),
    .re_i    (ctl.scan),
    .raddr_i ({ys[DIM_W-1:0], xs[DIM_W-1:0]}),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i) begin
    rd_in_q <= in_img;
    if (ctl.acc_clr) begin
      sum_r_q <= '0;
      sum_g_q <= '0;
      sum_b_q <= '0;
    end else if (rd_vld_q && rd_in_q) begin
      sum_r_q <= sum_r_q + SUM_W'(rd_data[3*CH_W-1 -: CH_W]);
      sum_g_q <= sum_g_q + SUM_W'(rd_data[2*CH_W-1 -: CH_W]);
      sum_b_q <= sum_b_q + SUM_W'(rd_data[CH_W-1:0]);
    end
  end

  // means
  iwcm_divider u_div_r (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl.div_start),
    .dividend_i ({sum_r_q, {FRAC_W{1'b0}}}),
    .divisor_i  (samples),
    .busy_o     (busy_r),
    .quot_o     (quot_r)
  );

  iwcm_divider u_div_g (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl.div_start),
    .dividend_i ({sum_g_q, {FRAC_W{1'b0}}}),
    .divisor_i  (samples),
    .busy_o     (busy_g),
    .quot_o     (quot_g)
  );

  iwcm_divider u_div_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl.div_start),
    .dividend_i ({sum_b_q, {FRAC_W{1'b0}}}),
    .divisor_i  (samples),
    .busy_o     (busy_b),
    .quot_o     (quot_b)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.out_load) begin
      mean_r_q <= zero_q ? '0 : quot_r;
      mean_g_q <= (zero_q || busy_g) ? '0 : quot_g;
      mean_b_q <= (zero_q || busy_b) ? '0 : quot_b;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mean_red_o   = mean_r_q;
  assign mean_green_o = mean_g_q;
  assign mean_blue_o  = mean_b_q;

endmodule

`default_nettype wire

// ===== rtl/iwcm_ram.sv =====
`default_nettype none

module iwcm_ram #(
  parameter int unsigned ADDR_W = 18,
  parameter int unsigned DATA_W = 24
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/iwcm_divider.sv =====
`default_nettype none

module iwcm_divider (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [iwcm_pkg::DVD_W-1:0]   dividend_i,
  input  wire logic [iwcm_pkg::DSR_W-1:0]   divisor_i,
  output logic                              busy_o,
  output logic      [iwcm_pkg::MEAN_W-1:0]  quot_o
);

  import iwcm_pkg::*;

  logic [DIV_BITS-1:0] dvd_q, dvd_d;
  logic [DSR_W-1:0]    rem_q, rem_d;
  logic [DSR_W-1:0]    dsr_q;
  logic [DCNT_W-1:0]   cnt_q;
  logic                busy_q;

  // two quotient bits per cycle, restoring
  always_comb begin
    logic [DSR_W:0] trial;
    dvd_d = dvd_q;
    rem_d = rem_q;
    for (int k = 0; k < 2; k++) begin
      trial = {rem_d, dvd_d[DIV_BITS-1]};
      dvd_d = {dvd_d[DIV_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d    = DSR_W'(trial - {1'b0, dsr_q});
        dvd_d[0] = 1'b1;
      end else begin
        rem_d = trial[DSR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DCNT_W'(DIV_STEPS);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - 1'b1;
      busy_q <= (cnt_q != DCNT_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= DIV_BITS'(dividend_i);
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = dvd_q[MEAN_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/iwcm_checker.sv =====
`default_nettype none

module iwcm_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_valid_i,
  input wire logic                            in_ready_o,
  input wire logic                            mode_i,
  input wire logic                            has_x_i,
  input wire logic                            has_y_i,
  input wire logic                            out_valid_o,
  input wire logic                            out_ready_i,
  input wire logic [iwcm_pkg::MEAN_W-1:0]     mean_red_o,
  input wire logic [iwcm_pkg::MEAN_W-1:0]     mean_green_o,
  input wire logic [iwcm_pkg::MEAN_W-1:0]     mean_blue_o
);

  import iwcm_pkg::*;

  a_write_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !mode_i) |=> in_ready_o)
    else $error("pixel write kept the input stalled");

  a_drop_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && mode_i && (!has_x_i || !has_y_i)) |=> in_ready_o)
    else $error("query without a coordinate was not dropped");

  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared while idle");

  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mean_red_o <= MEAN_W'(MEAN_MAX)) &&
                    (mean_green_o <= MEAN_W'(MEAN_MAX)) &&
                    (mean_blue_o <= MEAN_W'(MEAN_MAX)))
    else $error("mean above full scale");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(mean_red_o) &&
                                      $stable(mean_green_o) && $stable(mean_blue_o))
    else $error("stalled result changed");

endmodule

bind image_window_color_mean iwcm_checker u_iwcm_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
  import iwcm_pkg::*;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
  localparam int   STUCK_LIMIT = 8000;

  typedef struct {
    logic             mode;
    logic [8:0]       col;
    logic [8:0]       row;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [PT_W-1:0]  px;
    logic [PT_W-1:0]  py;
    logic             hx;
    logic             hy;
  } pixel_item_t;

  // index 2 red, 1 green, 0 blue
  typedef logic [2:0][MEAN_W-1:0] colour_mean_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic                 mode_i = 1'b0;
  logic [8:0]           pixel_col_i = '0;
  logic [8:0]           pixel_row_i = '0;
  logic [CH_W-1:0]      red_in_i = '0;
  logic [CH_W-1:0]      green_in_i = '0;
  logic [CH_W-1:0]      blue_in_i = '0;
  logic [PT_W-1:0]      point_x_i = '0;
  logic [PT_W-1:0]      point_y_i = '0;
  logic                 has_x_i = 1'b0;
  logic                 has_y_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [MEAN_W-1:0]    mean_red_o;
  logic [MEAN_W-1:0]    mean_green_o;
  logic [MEAN_W-1:0]    mean_blue_o;

  image_window_color_mean dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .pixel_col_i  (pixel_col_i),
    .pixel_row_i  (pixel_row_i),
    .red_in_i     (red_in_i),
    .green_in_i   (green_in_i),
    .blue_in_i    (blue_in_i),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .has_x_i      (has_x_i),
    .has_y_i      (has_y_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mean_red_o   (mean_red_o),
    .mean_green_o (mean_green_o),
    .mean_blue_o  (mean_blue_o)
  );

  always #2 clk_i = ~clk_i;

  // shadow of the block's state and registers
  logic [PIX_W-1:0] pixel_shadow [int];
  bit               image_loaded = 1'b0;
  logic [SQ_W-1:0]  square_cfg = 5'd5;
  logic [CFG_W-1:0] width_cfg = 10'd512;
  logic [CFG_W-1:0] height_cfg = 10'd512;

  colour_mean_t pending_means [$];
  int  fail_count = 0;
  int  items_sent = 0;
  int  means_checked = 0;
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  hold_req = 0;
  int  hold_left = 0;
  int  stuck_cycles = 0;

  function automatic int eff_dim(input logic [CFG_W-1:0] v);
    return (v > MAX_DIM) ? int'(MAX_DIM) : int'(v);
  endfunction

  function automatic int window_start(input logic [PT_W-1:0] frac, input int size,
                                      input int radius);
    int p;
    p = (int'(frac) * size) >> 16;
    if (p < radius) p = radius;
    if (p > size - radius) p = size - radius;
    return p - radius;
  endfunction

  function automatic colour_mean_t window_mean(input logic [PT_W-1:0] px,
                                               input logic [PT_W-1:0] py);
    int w, h, sq, rad, x0, y0, x, y, key, samples;
    int sum [3];
    logic [PIX_W-1:0] c;
    colour_mean_t m;
    w = eff_dim(width_cfg);
    h = eff_dim(height_cfg);
    sq = int'(square_cfg);
    rad = (sq + 1) / 2;
    x0 = window_start(px, w, rad);
    y0 = window_start(py, h, rad);
    sum = '{0, 0, 0};
    for (int i = 0; i < sq; i++) begin
      for (int j = 0; j < sq; j++) begin
        x = x0 + i;
        y = y0 + j;
        if (x >= 0 && x < w && y >= 0 && y < h) begin
          key = y * int'(MAX_DIM) + x;
          c = pixel_shadow.exists(key) ? pixel_shadow[key] : '0;
          for (int ch = 0; ch < 3; ch++) sum[ch] += int'(c[ch*CH_W +: CH_W]);
        end
      end
    end
    samples = sq * sq;
    for (int ch = 0; ch < 3; ch++)
      m[ch] = (samples == 0) ? '0 : MEAN_W'((sum[ch] * 256) / samples);
    return m;
  endfunction

  function automatic pixel_item_t random_item();
    pixel_item_t it;
    it.mode  = 1'($urandom);
    it.col   = 9'($urandom);
    it.row   = 9'($urandom);
    it.red   = 8'($urandom);
    it.green = 8'($urandom);
    it.blue  = 8'($urandom);
    it.px    = 16'($urandom);
    it.py    = 16'($urandom);
    it.hx    = 1'($urandom);
    it.hy    = 1'($urandom);
    return it;
  endfunction

  function automatic void apply_item(input pixel_item_t it);
    if (it.mode == MODE_WRITE) begin
      pixel_shadow[int'({it.row, it.col})] = {it.red, it.green, it.blue};
      image_loaded = 1'b1;
    end else if (image_loaded && it.hx && it.hy) begin
      pending_means.insert(pending_means.size(), window_mean(it.px, it.py));
    end
  endfunction

  // starts and ends at a falling edge; valid is left high for a following item
  task automatic send_item(input pixel_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= it.mode;
    pixel_col_i <= it.col;
    pixel_row_i <= it.row;
    red_in_i    <= it.red;
    green_in_i  <= it.green;
    blue_in_i   <= it.blue;
    point_x_i   <= it.px;
    point_y_i   <= it.py;
    has_x_i     <= it.hx;
    has_y_i     <= it.hy;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    apply_item(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_pixel(input int col, input int row, input logic [PIX_W-1:0] rgb);
    pixel_item_t it;
    it = random_item();
    it.mode = MODE_WRITE;
    it.col = 9'(col);
    it.row = 9'(row);
    {it.red, it.green, it.blue} = rgb;
    send_item(it);
  endtask

  // writes every in-image pixel of the window that has not been written yet
  task automatic cover_window(input logic [PT_W-1:0] px, input logic [PT_W-1:0] py);
    int w, h, sq, rad, x0, y0, x, y;
    w = eff_dim(width_cfg);
    h = eff_dim(height_cfg);
    sq = int'(square_cfg);
    rad = (sq + 1) / 2;
    x0 = window_start(px, w, rad);
    y0 = window_start(py, h, rad);
    for (int i = 0; i < sq; i++) begin
      for (int j = 0; j < sq; j++) begin
        x = x0 + i;
        y = y0 + j;
        if (x >= 0 && x < w && y >= 0 && y < h &&
            !pixel_shadow.exists(y * int'(MAX_DIM) + x))
          write_pixel(x, y, PIX_W'($urandom));
      end
    end
  endtask

  task automatic query_at(input logic [PT_W-1:0] px, input logic [PT_W-1:0] py);
    pixel_item_t it;
    cover_window(px, py);
    it = random_item();
    it.mode = MODE_QUERY;
    it.px = px;
    it.py = py;
    it.hx = 1'b1;
    it.hy = 1'b1;
    send_item(it);
  endtask

  task automatic query_missing_coord();
    pixel_item_t it;
    int pick;
    it = random_item();
    pick = $urandom_range(2);
    it.mode = MODE_QUERY;
    it.hx = pick[0];
    it.hy = pick[1];
    send_item(it);
  endtask

  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_means.size() != 0) @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    repeat (int'(square_cfg) * int'(square_cfg) + 32) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      REG_SQUARE: square_cfg = val[SQ_W-1:0];
      REG_WIDTH:  width_cfg = val;
      REG_HEIGHT: height_cfg = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input int sq, input int w, input int h);
    settle_block();
    write_reg(REG_SQUARE, CFG_W'(sq));
    write_reg(REG_WIDTH, CFG_W'(w));
    write_reg(REG_HEIGHT, CFG_W'(h));
  endtask

  // full queries, then one missing a coordinate, before any pixel write: all dropped
  task automatic check_unloaded_queries();
    pixel_item_t it;
    repeat (3) begin
      it = random_item();
      it.mode = MODE_QUERY;
      it.hx = 1'b1;
      it.hy = 1'b1;
      send_item(it);
    end
    query_missing_coord();
  endtask

  task automatic check_corner_windows();
    set_config(1, 512, 512);
    write_pixel(0, 0, 24'hFFFFFF);
    write_pixel(511, 511, 24'h000000);
    write_pixel(510, 510, 24'hFF0080);
    query_at(16'h0000, 16'h0000);
    query_at(16'hFFFF, 16'hFFFF);
    query_at(16'h0000, 16'hFFFF);
    query_at(16'h8000, 16'h8000);
    repeat (3) query_missing_coord();
  endtask

  task automatic check_size_corners();
    set_config(0, 512, 512);
    query_at(16'h1234, 16'h5678);
    set_config(5, 0, 0);
    query_at(16'hFFFF, 16'h0000);
    set_config(1, 1023, 1023);
    query_at(16'hFFFF, 16'hFFFF);
    query_at(16'h0000, 16'h0000);
    set_config(5, 2, 3);
    query_at(16'h0000, 16'hFFFF);
    query_at(16'hC000, 16'h4000);
    set_config(31, 1, 1);
    query_at(16'h0000, 16'h0000);
    query_at(16'hFFFF, 16'h0000);
    set_config(31, 512, 1);
    query_at(16'h8000, 16'h0000);
  endtask

  // output held off for a long stretch while queries keep coming
  task automatic check_stalled_output();
    logic [PT_W-1:0] xs [8];
    logic [PT_W-1:0] ys [8];
    send_idle_pct = 0;
    stall_pct = 0;
    set_config(3, 16, 16);
    for (int k = 0; k < 8; k++) begin
      xs[k] = 16'($urandom);
      ys[k] = 16'($urandom);
      query_at(xs[k], ys[k]);
    end
    settle_block();
    @(posedge clk_i);
    hold_req = 400;
    @(negedge clk_i);
    for (int k = 0; k < 8; k++) query_at(xs[k], ys[k]);
    settle_block();
    for (int k = 0; k < 4; k++) query_at(ys[k], xs[k]);
  endtask

  task automatic run_traffic_phase(input int idle_pct, input int stall, input int n);
    int start, sq, w, h, roll;
    pixel_item_t it;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    start = items_sent;
    while (items_sent - start < n) begin
      if ($urandom_range(9) < 8) begin
        sq = $urandom_range(1, 7);
        w = ($urandom_range(9) == 0) ? 512 : $urandom_range(1, 24);
        h = ($urandom_range(9) == 0) ? 512 : $urandom_range(1, 24);
      end else begin
        sq = $urandom_range(8, 31);
        w = $urandom_range(1, 10);
        h = $urandom_range(1, 10);
      end
      set_config(sq, w, h);
      repeat ($urandom_range(15, 30)) begin
        roll = $urandom_range(99);
        if (roll < 65) begin
          query_at(16'($urandom), 16'($urandom));
        end else if (roll < 85) begin
          it = random_item();
          it.mode = MODE_WRITE;
          send_item(it);
        end else begin
          query_missing_coord();
        end
      end
      // sender waits for every outstanding mean now and then
      if ($urandom_range(3) == 0) settle_block();
    end
  endtask

  // receiver
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result check
  always @(posedge clk_i) begin
    colour_mean_t got, want;
    string ch_name [3];
    ch_name = '{"blue", "green", "red"};
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {mean_red_o, mean_green_o, mean_blue_o};
      if (pending_means.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result r=%h g=%h b=%h", $time,
                 got[2], got[1], got[0]);
      end else begin
        want = pending_means.pop_front();
        means_checked++;
        for (int ch = 2; ch >= 0; ch--) begin
          if (got[ch] !== want[ch]) begin
            fail_count++;
            $display("%0t: mean_%s expected %h actual %h", $time, ch_name[ch],
                     want[ch], got[ch]);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk_i);
    $display("%0t: no transfer for %0d cycles, %0d means outstanding", $time,
             STUCK_LIMIT, pending_means.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    check_unloaded_queries();
    check_corner_windows();
    check_size_corners();
    run_traffic_phase(0, 0, 60);
    run_traffic_phase(66, 0, 60);
    run_traffic_phase(0, 66, 60);
    check_stalled_output();
    run_traffic_phase(37, 37, 60);
    settle_block();
    $display("Covered %0d pixel writes and queries, %0d window means checked;", items_sent,
             means_checked);
    $display("squares 0..31, image sizes 0..1023, idle and stall mixes, long output hold-off.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== image_window_color_mean.f =====
rtl/iwcm_pkg.sv
rtl/iwcm_ram.sv
rtl/iwcm_divider.sv
rtl/image_window_color_mean.sv
rtl/iwcm_checker.sv
tb/tb_top.sv
